// ===== rtl/idfl_pkg.sv =====
// idfl_pkg: shared field widths, request and status codes and the result type
// of the ID free-list allocator. No dependencies.
package idfl_pkg;

  localparam int KIND_W   = 2;
  localparam int NUM_W    = 10;
  localparam int CFG_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_GET     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    value;
    logic                available;
  } idfl_result_t;

endpackage

// ===== rtl/idfl_ram.sv =====
// idfl_ram: single-write, single-read synchronous RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
module idfl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 1
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/idfl_ctrl.sv =====
// idfl_ctrl: allocator state (limit, stack depth, fresh counter, cached stack
// top, mark forwarding) and the per-beat update. Depends on idfl_pkg.
module idfl_ctrl
  import idfl_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                adv,
  input  logic [KIND_W-1:0]   item_kind,
  input  logic [NUM_W-1:0]    item_number,
  input  logic                mark_rd,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] stk_rd,
  output idfl_result_t        res,
  output logic                mark_we,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mark_waddr,
  output logic                mark_wdata,
  output logic                stk_we,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] stk_waddr,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] stk_wdata,
  output logic                stk_re,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] stk_raddr
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > CFG_W) ? CW : CFG_W;

  logic [CW-1:0] max_r, max_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic [IW-1:0] top_r, top_nxt;
  logic          pend_r, pend_nxt;
  logic          fwd_vld_r;
  logic [IW-1:0] fwd_addr_r;
  logic          fwd_data_r;

  logic [IW-1:0] top_eff;
  logic [IW-1:0] num_idx;
  logic          num_in;
  logic          mark_eff;
  logic          mark_w;
  logic          stk_w;
  logic          stk_r;

  assign top_eff = pend_r ? stk_rd : top_r;
  assign num_idx = IW'(item_number);
  assign num_in  = XW'(item_number) < XW'(max_r);

  always_comb begin
    if (XW'(item_number) >= XW'(fresh_r)) begin
      mark_eff = 1'b1;
    end else if (fwd_vld_r && (fwd_addr_r == num_idx)) begin
      mark_eff = fwd_data_r;
    end else begin
      mark_eff = mark_rd;
    end
  end

  always_comb begin
    if (XW'(cfg_data) > XW'(CAPACITY)) begin
      max_nxt = CW'(CAPACITY);
    end else begin
      max_nxt = CW'(cfg_data);
    end
  end

  always_comb begin
    res        = '0;
    res.status = ST_OK;
    count_nxt  = count_r;
    fresh_nxt  = fresh_r;
    top_nxt    = top_eff;
    pend_nxt   = 1'b0;
    mark_w     = 1'b0;
    mark_waddr = num_idx;
    mark_wdata = 1'b0;
    stk_w      = 1'b0;
    stk_waddr  = IW'(count_r - CW'(1));
    stk_wdata  = top_eff;
    stk_r      = 1'b0;
    stk_raddr  = IW'(count_r - CW'(2));
    case (item_kind)
      KIND_GET: begin
        if (count_r != '0) begin
          res.value  = NUM_W'(top_eff);
          count_nxt  = count_r - CW'(1);
          mark_w     = 1'b1;
          mark_waddr = top_eff;
          if (count_r > CW'(1)) begin
            stk_r    = 1'b1;
            pend_nxt = 1'b1;
          end
        end else if (fresh_r < max_r) begin
          res.value  = NUM_W'(fresh_r);
          fresh_nxt  = fresh_r + CW'(1);
          mark_w     = 1'b1;
          mark_waddr = IW'(fresh_r);
        end else begin
          res.status = ST_NONE;
        end
      end
      KIND_CHECK: begin
        if (!num_in) begin
          res.status = ST_RANGE;
        end else begin
          res.available = mark_eff;
        end
      end
      KIND_RELEASE: begin
        if (!num_in) begin
          res.status = ST_RANGE;
        end else if (!mark_eff) begin
          stk_w      = (count_r != '0);
          top_nxt    = num_idx;
          count_nxt  = count_r + CW'(1);
          mark_w     = 1'b1;
          mark_wdata = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign mark_we = adv & mark_w;
  assign stk_we  = adv & stk_w;
  assign stk_re  = adv & stk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= CW'(CAPACITY);
      count_r   <= '0;
      fresh_r   <= '0;
      pend_r    <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else if (cfg_we) begin
      max_r     <= max_nxt;
      count_r   <= '0;
      fresh_r   <= '0;
      pend_r    <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else if (adv) begin
      count_r   <= count_nxt;
      fresh_r   <= fresh_nxt;
      pend_r    <= pend_nxt;
      fwd_vld_r <= mark_w;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      top_r      <= top_nxt;
      fwd_addr_r <= mark_waddr;
      fwd_data_r <= mark_wdata;
    end
  end

endmodule

// ===== rtl/id_free_list_allocator.sv =====
// ID free-list allocator: get, check and release of numbered IDs below a
// programmable limit, with mark and released-ID memories.
// Depends on idfl_pkg, idfl_ram and idfl_ctrl.
//
// Usage:
//   Input beat (in_valid/in_stall): in_kind = get, check or release, and
//   in_number for check and release. Result beat (out_valid/out_stall):
//   out_status, out_value (granted ID) and out_available (check result).
//   One result beat per input beat, in order.
//   cfg_we with cfg_data sets the ID limit and makes every ID free; write it
//   only with no beat in flight.
// Timing:
//   An accepted beat reads the mark memory as it is accepted, is resolved
//   in the resolve stage and enters the output register when that stage
//   advances. One beat per cycle while out_stall is low; the cached stack
//   top and one-deep mark forwarding cover back-to-back access to one entry.
// Reset: limit = CAPACITY, all IDs free, stack empty; no clearing pass,
//   since IDs at or above the fresh counter read as free.
// Stall: a held result stalls the resolve stage, and in_stall rises with it
//   while that stage holds a beat; nothing is dropped.
module id_free_list_allocator
  import idfl_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [NUM_W-1:0]    in_number,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [NUM_W-1:0]    out_value,
  output logic                out_available
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                b_vld_r;
  logic [KIND_W-1:0]   b_kind_r;
  logic [NUM_W-1:0]    b_num_r;
  logic                out_vld_r;
  idfl_result_t        out_res_r;

  logic                accept;
  logic                b_adv;
  idfl_result_t        res;
  logic                mark_rd;
  logic                mark_we;
  logic [IW-1:0]       mark_waddr;
  logic                mark_wdata;
  logic [IW-1:0]       stk_rd;
  logic                stk_we;
  logic [IW-1:0]       stk_waddr;
  logic [IW-1:0]       stk_wdata;
  logic                stk_re;
  logic [IW-1:0]       stk_raddr;

  assign b_adv    = b_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = b_vld_r & ~b_adv;
  assign accept   = in_valid & ~in_stall;

  idfl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (1)
  ) u_mark_ram (
    .clk     (clk),
    .wr_en   (mark_we),
    .wr_addr (mark_waddr),
    .wr_data (mark_wdata),
    .rd_en   (accept),
    .rd_addr (IW'(in_number)),
    .rd_data (mark_rd)
  );

  idfl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (IW)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_rd)
  );

  idfl_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .adv         (b_adv),
    .item_kind   (b_kind_r),
    .item_number (b_num_r),
    .mark_rd     (mark_rd),
    .stk_rd      (stk_rd),
    .res         (res),
    .mark_we     (mark_we),
    .mark_waddr  (mark_waddr),
    .mark_wdata  (mark_wdata),
    .stk_we      (stk_we),
    .stk_waddr   (stk_waddr),
    .stk_wdata   (stk_wdata),
    .stk_re      (stk_re),
    .stk_raddr   (stk_raddr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        b_vld_r <= 1'b1;
      end else if (b_adv) begin
        b_vld_r <= 1'b0;
      end
      if (b_adv) begin
        out_vld_r <= 1'b1;
      end else if (~out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_kind_r <= in_kind;
      b_num_r  <= in_number;
    end
    if (b_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_status    = out_res_r.status;
  assign out_value     = out_res_r.value;
  assign out_available = out_res_r.available;

`ifndef NO_ASSERTIONS
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    b_adv |=> out_vld_r)
    else $error("resolved beat did not reach the output register");

  a_fail_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_res_r.status != ST_OK) |->
      (out_res_r.value == '0) && !out_res_r.available)
    else $error("failed beat carries a value or availability");

  a_avail_is_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.available |->
      (out_res_r.status == ST_OK) && (out_res_r.value == '0))
    else $error("available set on a beat that is not a good check");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> b_vld_r && $stable(b_kind_r) && $stable(b_num_r))
    else $error("resolve stage changed while input was stalled");
`endif

endmodule
